// File: src/alignment_conservation_symbol_unit_macros.svh
// Assertion macros shared by the conservation symbol unit modules.
`ifndef ALIGNMENT_CONSERVATION_SYMBOL_UNIT_MACROS_SVH
`define ALIGNMENT_CONSERVATION_SYMBOL_UNIT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define ACS_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ACS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/acs_pkg.sv
// Shared types, constants and helper functions of the conservation symbol unit.
package acs_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int HIST_IDX_W    = $clog2(ALPHABET_SIZE);
    localparam int LETTER_W      = 8;
    localparam int COUNT_W       = 11;
    localparam int APB_ADDR_W    = 4;
    localparam int APB_DATA_W    = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_TWO_SEQ = 2'd0;
    localparam logic [1:0] REG_WILD_A  = 2'd1;
    localparam logic [1:0] REG_WILD_B  = 2'd2;

    // Conservation symbol codes
    localparam logic [1:0] SYM_BLANK = 2'd0;
    localparam logic [1:0] SYM_STAR  = 2'd1;
    localparam logic [1:0] SYM_COLON = 2'd2;
    localparam logic [1:0] SYM_DOT   = 2'd3;

    // Characters
    localparam logic [LETTER_W-1:0] CHAR_DASH    = 8'h2D;
    localparam logic [LETTER_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [LETTER_W-1:0] CHAR_LOW_A   = 8'h61;
    localparam logic [LETTER_W-1:0] CHAR_LOW_Z   = 8'h7A;
    localparam logic [LETTER_W-1:0] CASE_OFFSET  = 8'h20;
    localparam logic [LETTER_W-1:0] WILD_A_RESET = 8'h58;
    localparam logic [LETTER_W-1:0] WILD_B_RESET = 8'h4E;

    typedef struct packed {
        logic                two_seq;
        logic [LETTER_W-1:0] wild_a;
        logic [LETTER_W-1:0] wild_b;
    } acs_cfg_t;

    typedef struct packed {
        logic [1:0]         symbol;
        logic [COUNT_W-1:0] counted;
        logic [COUNT_W-1:0] top;
    } acs_result_t;

    function automatic logic [LETTER_W-1:0] upcase(input logic [LETTER_W-1:0] c);
        logic [LETTER_W-1:0] r;
        r = c;
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
            r = c - CASE_OFFSET;
        return r;
    endfunction

    function automatic logic is_gap(input logic [LETTER_W-1:0] c);
        return (c == CHAR_DASH) || (c == CHAR_DOT);
    endfunction

    // Clustal-style thresholds as integer cross-multiplications
    function automatic logic [1:0] general_symbol(input logic [COUNT_W-1:0] top,
                                                  input logic [COUNT_W-1:0] count);
        logic [COUNT_W+1:0] top4;
        logic [COUNT_W+1:0] top2;
        logic [COUNT_W+1:0] cnt3;
        logic [COUNT_W+1:0] cnt1;
        logic [1:0]         sym;
        top4 = {top, 2'b00};
        top2 = {1'b0, top, 1'b0};
        cnt1 = {2'b00, count};
        cnt3 = cnt1 + {1'b0, count, 1'b0};
        if (count < COUNT_W'(2))
            sym = SYM_BLANK;
        else if (top == count)
            sym = SYM_STAR;
        else if (top4 >= cnt3)
            sym = SYM_COLON;
        else if (top2 >= cnt1 && count > COUNT_W'(2))
            sym = SYM_DOT;
        else
            sym = SYM_BLANK;
        return sym;
    endfunction

    function automatic logic [1:0] pair_symbol(input logic [LETTER_W-1:0] a,
                                               input logic [LETTER_W-1:0] b);
        logic [1:0] sym;
        sym = SYM_BLANK;
        if (!is_gap(a) && !is_gap(b) && upcase(a) == upcase(b))
            sym = SYM_STAR;
        return sym;
    endfunction

endpackage

// File: src/acs_cfg_regs.sv
// APB configuration registers: pair mode and the two wildcard letters.
module acs_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [acs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [acs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output acs_pkg::acs_cfg_t                  cfg
);

    logic                            two_seq_reg;
    logic [acs_pkg::LETTER_W-1:0]    wild_a_reg;
    logic [acs_pkg::LETTER_W-1:0]    wild_b_reg;
    logic                            wr_en;
    logic [1:0]                      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_seq_reg <= 1'b0;
            wild_a_reg  <= acs_pkg::WILD_A_RESET;
            wild_b_reg  <= acs_pkg::WILD_B_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                acs_pkg::REG_TWO_SEQ: two_seq_reg <= pwdata[0];
                acs_pkg::REG_WILD_A:  wild_a_reg  <= pwdata[acs_pkg::LETTER_W-1:0];
                acs_pkg::REG_WILD_B:  wild_b_reg  <= pwdata[acs_pkg::LETTER_W-1:0];
                default:              ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            acs_pkg::REG_TWO_SEQ: prdata = acs_pkg::APB_DATA_W'(two_seq_reg);
            acs_pkg::REG_WILD_A:  prdata = acs_pkg::APB_DATA_W'(wild_a_reg);
            acs_pkg::REG_WILD_B:  prdata = acs_pkg::APB_DATA_W'(wild_b_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.two_seq = two_seq_reg;
    assign cfg.wild_a  = wild_a_reg;
    assign cfg.wild_b  = wild_b_reg;

endmodule

// File: src/acs_column.sv
// Column datapath: histogram memory read-modify-write, column counters, symbol.
`include "alignment_conservation_symbol_unit_macros.svh"

module acs_column (
    input  logic                             clk,
    input  logic                             rst_n,
    input  acs_pkg::acs_cfg_t                cfg,
    input  logic                             accept,
    input  logic [acs_pkg::LETTER_W-1:0]     letter,
    input  logic                             last_in_column,
    output logic                             push,
    output acs_pkg::acs_result_t             push_data,
    output logic                             stage_last
);

    localparam int IW = acs_pkg::HIST_IDX_W;
    localparam int CW = acs_pkg::COUNT_W;

    // Histogram store; entries are qualified by per-column valid bits
    logic [CW-1:0]                    hist_mem [acs_pkg::ALPHABET_SIZE];
    logic [CW-1:0]                    rd_data_reg;
    logic [acs_pkg::ALPHABET_SIZE-1:0] hist_valid_reg;

    // Stage register
    logic                             s1_valid_reg;
    logic [acs_pkg::LETTER_W-1:0]     s1_letter_reg;
    logic                             s1_last_reg;

    // Write-to-read forwarding
    logic                             wr_recent_reg;
    logic [IW-1:0]                    wr_idx_reg;
    logic [CW-1:0]                    wr_val_reg;

    // Column state
    logic [CW-1:0]                    count_reg;
    logic [CW-1:0]                    largest_reg;
    logic [acs_pkg::LETTER_W-1:0]     first_letter_reg;
    logic                             awaiting_reg;

    logic [acs_pkg::LETTER_W-1:0]     in_up;
    logic [IW-1:0]                    in_idx;
    logic [acs_pkg::LETTER_W-1:0]     s1_up;
    logic [IW-1:0]                    s1_idx;
    logic                             s1_counts;
    logic [CW-1:0]                    n_old;
    logic [CW-1:0]                    n_new;
    logic [CW-1:0]                    largest_new;
    logic [CW-1:0]                    count_new;
    logic                             hist_we;
    logic [1:0]                       sym;

    assign in_up  = acs_pkg::upcase(letter);
    assign in_idx = in_up[IW-1:0];

    // Histogram memory: read on accept, write from the stage
    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= hist_mem[in_idx];
        if (hist_we)
            hist_mem[s1_idx] <= n_new;
    end

    // Stage evaluation
    always_comb
    begin
        s1_up     = acs_pkg::upcase(s1_letter_reg);
        s1_idx    = s1_up[IW-1:0];
        s1_counts = !acs_pkg::is_gap(s1_letter_reg) && (s1_up != cfg.wild_a)
                    && (s1_up != cfg.wild_b)
                    && ({1'b0, s1_up} < 9'(acs_pkg::ALPHABET_SIZE));

        // Previous item's write lands at the same edge as this item's read
        if (wr_recent_reg && wr_idx_reg == s1_idx)
            n_old = wr_val_reg;
        else if (hist_valid_reg[s1_idx])
            n_old = rd_data_reg;
        else
            n_old = '0;

        n_new = (n_old == acs_pkg::COUNT_MAX) ? n_old : n_old + CW'(1);

        largest_new = largest_reg;
        count_new   = count_reg;
        if (s1_counts)
        begin
            if (n_new > largest_reg)
                largest_new = n_new;
            if (count_reg != acs_pkg::COUNT_MAX)
                count_new = count_reg + CW'(1);
        end

        hist_we = s1_valid_reg && s1_counts && !s1_last_reg;

        if (cfg.two_seq)
            sym = awaiting_reg ? acs_pkg::pair_symbol(first_letter_reg, s1_letter_reg)
                               : acs_pkg::SYM_BLANK;
        else
            sym = acs_pkg::general_symbol(largest_new, count_new);
    end

    assign push              = s1_valid_reg && s1_last_reg;
    assign stage_last        = push;
    assign push_data.symbol  = sym;
    assign push_data.counted = count_new;
    assign push_data.top     = largest_new;

    // Stage payload and forwarding data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_letter_reg <= letter;
            s1_last_reg   <= last_in_column;
        end
        wr_idx_reg <= s1_idx;
        wr_val_reg <= n_new;
    end

    // Control and column state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            wr_recent_reg    <= 1'b0;
            hist_valid_reg   <= '0;
            count_reg        <= '0;
            largest_reg      <= '0;
            first_letter_reg <= '0;
            awaiting_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            wr_recent_reg <= hist_we;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    // Column end: everything back to empty
                    hist_valid_reg   <= '0;
                    count_reg        <= '0;
                    largest_reg      <= '0;
                    first_letter_reg <= '0;
                    awaiting_reg     <= 1'b0;
                end
                else
                begin
                    count_reg   <= count_new;
                    largest_reg <= largest_new;
                    if (!awaiting_reg)
                    begin
                        first_letter_reg <= s1_letter_reg;
                        awaiting_reg     <= 1'b1;
                    end
                    if (hist_we)
                        hist_valid_reg[s1_idx] <= 1'b1;
                end
            end
        end
    end

    `ACS_ASSERT_HOLDS(a_top_le_count, largest_reg <= count_reg, "top count above letter count")
    `ACS_ASSERT_NEXT(a_column_cleared, s1_valid_reg && s1_last_reg, count_reg == '0 && largest_reg == '0 && !awaiting_reg && hist_valid_reg == '0, "column state not cleared")
    `ACS_ASSERT_IMPLY(a_empty_column, !awaiting_reg, count_reg == '0, "letters counted before first letter held")
    `ACS_ASSERT_IMPLY(a_forward_source, wr_recent_reg, $past(s1_valid_reg) && !$past(s1_last_reg), "forwarded write without a counted stage item")

endmodule

// File: src/acs_out_queue.sv
// Two-entry result queue that decouples the column stage from the consumer.
`include "alignment_conservation_symbol_unit_macros.svh"

module acs_out_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  acs_pkg::acs_result_t  push_data,
    input  logic                  stage_last,
    input  logic                  out_stall,
    output logic                  out_valid,
    output acs_pkg::acs_result_t  out_data,
    output logic                  in_stall
);

    acs_pkg::acs_result_t head_reg;
    acs_pkg::acs_result_t tail_reg;
    acs_pkg::acs_result_t head_next;
    acs_pkg::acs_result_t tail_next;
    logic [1:0]           count_reg;
    logic [1:0]           count_next;
    logic                 pop;
    logic [2:0]           occupancy;

    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign pop       = out_valid && !out_stall;

    // Hold input when the item in the stage plus a new one might not fit
    assign occupancy = 3'(count_reg) + 3'(stage_last) - 3'(pop);
    assign in_stall  = (occupancy > 3'd1);

    // Queue update
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_next = tail_reg;
                if (push)
                    tail_next = push_data;
            end
            else if (push)
                head_next = push_data;
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
                head_next = push_data;
            else
                tail_next = push_data;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    `ACS_ASSERT_HOLDS(a_count_bound, count_reg <= 2'd2, "result queue over capacity")
    `ACS_ASSERT_IMPLY(a_push_room, push, count_reg != 2'd2 || pop, "push into full result queue")
    `ACS_ASSERT_IMPLY(a_stall_when_full, count_reg == 2'd2 && !pop, in_stall, "input taken while queue full")

endmodule

// File: src/alignment_conservation_symbol_unit.sv
// Top level of the alignment column conservation symbol unit.
// Letters of one alignment column enter one per cycle on the letter channel, the final
// letter flagged by last_in_column; the unit sustains one letter every cycle while not
// stalled, and the column's result (symbol, counted letters, top count) passes through
// the stage register and the result queue register before it is valid on the result
// channel. Each letter does one read-modify-write of a 256-entry histogram memory
// (read registered at accept, written from the stage in the following cycle, with
// forwarding between neighbors); per-entry valid bits clear together at column end, so
// no clearing pass is needed and a new column may follow at once. A two-entry result
// queue lets letters keep flowing while a result waits; the letter channel stalls only
// when the queue cannot take the next result. The user must write configuration
// through the APB port only while no column is in progress; nothing enforces it.
module alignment_conservation_symbol_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [acs_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [acs_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [acs_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    // Letter channel
    input  logic                               letter_valid,
    output logic                               letter_stall,
    input  logic [acs_pkg::LETTER_W-1:0]       letter,
    input  logic                               last_in_column,
    // Result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [1:0]                         symbol,
    output logic [acs_pkg::COUNT_W-1:0]        counted_letters,
    output logic [acs_pkg::COUNT_W-1:0]        top_count
);

    acs_pkg::acs_cfg_t    cfg;
    acs_pkg::acs_result_t push_data;
    acs_pkg::acs_result_t out_data;
    logic                 push;
    logic                 stage_last;
    logic                 accept;

    assign accept = letter_valid && !letter_stall;

    // Configuration registers
    acs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Histogram and column logic
    acs_column u_column (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .accept         (accept),
        .letter         (letter),
        .last_in_column (last_in_column),
        .push           (push),
        .push_data      (push_data),
        .stage_last     (stage_last)
    );

    // Result queue
    acs_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .stage_last (stage_last),
        .out_stall  (result_stall),
        .out_valid  (result_valid),
        .out_data   (out_data),
        .in_stall   (letter_stall)
    );

    assign symbol          = out_data.symbol;
    assign counted_letters = out_data.counted;
    assign top_count       = out_data.top;

endmodule
